// ===== hw/rtl/sso_pkg.sv =====
// sso_pkg: shared widths, register codes, plant constants and the gain bus type
// for the second-order state observer; no dependencies
package sso_pkg;

  localparam int IO_W      = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int GAIN_W    = 28;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P1R = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P1I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P2R = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P2I = 2'd3;

  // gain pipeline depth after reset or a register write
  localparam logic [1:0] SETTLE_CYC = 2'd3;

  // plant constants: G and H in q2.30, G^2 in q4.28, ackermann scale in q16.16
  localparam logic signed [30:0] C_G00  = 31'sd1066717405;
  localparam logic signed [23:0] C_G10  = 24'sd7000797;
  localparam logic signed [28:0] C_GA00 = 29'sd264934735;
  localparam logic signed [22:0] C_GA10 = 23'sd3477499;
  localparam logic signed [25:0] C_H0   = 26'sd22759032;
  localparam logic signed [17:0] C_H1   = 18'sd74088;
  localparam logic signed [24:0] C_K    = 25'sd10051534;

  typedef struct packed {
    logic                     valid;
    logic signed [GAIN_W-1:0] l0;
    logic signed [GAIN_W-1:0] l1;
  } gain_bus_t;

endpackage

// ===== hw/rtl/sso_in_if.sv =====
// sso_in_if: input channel of the observer, valid/ready with drive and measurement
// depends on sso_pkg
interface sso_in_if;
  import sso_pkg::*;

  logic            valid;
  logic            ready;
  logic [IO_W-1:0] drive_voltage;
  logic [IO_W-1:0] measured_output;

  modport source (output valid, output drive_voltage, output measured_output, input ready);
  modport sink (input valid, input drive_voltage, input measured_output, output ready);

endinterface

// ===== hw/rtl/sso_out_if.sv =====
// sso_out_if: result channel of the observer, valid/ready with the new estimates
// depends on sso_pkg
interface sso_out_if;
  import sso_pkg::*;

  logic            valid;
  logic            ready;
  logic [IO_W-1:0] estimated_output;
  logic [IO_W-1:0] estimation_error;
  logic [IO_W-1:0] estimated_first_state;

  modport source (output valid, output estimated_output, output estimation_error,
                  output estimated_first_state, input ready);
  modport sink (input valid, input estimated_output, input estimation_error,
                input estimated_first_state, output ready);

endinterface

// ===== hw/rtl/sso_gain.sv =====
// sso_gain: pole registers and three-stage pipeline forming the observer gains
// depends on sso_pkg
module sso_gain (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sso_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sso_pkg::CFG_W-1:0]        cfg_data,
  output sso_pkg::gain_bus_t               gains
);
  import sso_pkg::*;

  logic signed [CFG_W-1:0] p1r_r, p1i_r, p2r_r, p2i_r;
  logic [1:0]              cnt_r;

  logic signed [CFG_W:0]   b;
  logic signed [31:0]      c1_nxt, c2_nxt, c1_r, c2_r;
  logic signed [47:0]      gb0_nxt, gb0_r;
  logic signed [40:0]      gb1_nxt, gb1_r;
  logic signed [33:0]      s0_nxt, s0_r;
  logic signed [24:0]      s1_nxt, s1_r;
  logic signed [58:0]      k0, k0_rnd;
  logic signed [49:0]      k1, k1_rnd;
  logic signed [GAIN_W-1:0] l0_nxt, l1_nxt, l0_r, l1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1r_r <= '0;
      p1i_r <= '0;
      p2r_r <= '0;
      p2i_r <= '0;
      cnt_r <= SETTLE_CYC;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_P1R: p1r_r <= $signed(cfg_data);
        REG_P1I: p1i_r <= $signed(cfg_data);
        REG_P2R: p2r_r <= $signed(cfg_data);
        REG_P2I: p2i_r <= $signed(cfg_data);
        default: ;
      endcase
      cnt_r <= SETTLE_CYC;
    end else if (cnt_r != 2'd0) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // stage 1: pole products and G*b
  always_comb begin
    b       = $signed({p1r_r, 1'b0});
    c1_nxt  = p1r_r * p2r_r;
    c2_nxt  = p1i_r * p2i_r;
    gb0_nxt = C_G00 * b;
    gb1_nxt = C_G10 * b;
  end

  // stage 2: inner sums in q.28
  always_comb begin
    s0_nxt = 34'(C_GA00) + 34'($signed(gb0_r[47:16])) + 34'(c1_r) + 34'(c2_r);
    s1_nxt = 25'(C_GA10) + $signed(gb1_r[40:16]);
  end

  // stage 3: scale and round half up to q12.16
  always_comb begin
    k0     = C_K * s0_r;
    k0_rnd = k0 + 59'sd134217728;
    k1     = C_K * s1_r;
    k1_rnd = k1 + 50'sd134217728;
    l0_nxt = $signed(k0_rnd[55:28]);
    l1_nxt = GAIN_W'($signed(k1_rnd[49:28]));
  end

  always_ff @(posedge clk) begin
    c1_r  <= c1_nxt;
    c2_r  <= c2_nxt;
    gb0_r <= gb0_nxt;
    gb1_r <= gb1_nxt;
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    l0_r  <= l0_nxt;
    l1_r  <= l1_nxt;
  end

  assign gains.valid = (cnt_r == 2'd0);
  assign gains.l0    = l0_r;
  assign gains.l1    = l1_r;

endmodule

// ===== hw/rtl/sso_core.sv =====
// sso_core: input register, state update and result register of the observer
// depends on sso_pkg, sso_in_if, sso_out_if
module sso_core #(
  parameter int EFF_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sso_pkg::gain_bus_t gains,
  sso_in_if.sink             in_ch,
  sso_out_if.source          out_ch
);
  import sso_pkg::*;

  localparam int ACC_W = GAIN_W + EFF_W - 5;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(128);

  function automatic logic signed [EFF_W-1:0] sat_e(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-EFF_W:0] hi;
    hi = v[ACC_W-1:EFF_W-1];
    if ((hi == '0) || (hi == '1)) sat_e = v[EFF_W-1:0];
    else if (v[ACC_W-1]) sat_e = {1'b1, {(EFF_W-1){1'b0}}};
    else sat_e = {1'b0, {(EFF_W-1){1'b1}}};
  endfunction

  logic                    valid_a_r, valid_b_r;
  logic signed [EFF_W-1:0] u_a_r, y_a_r;
  logic signed [EFF_W-1:0] x0_r, x1_r;
  logic [IO_W-1:0]         est_r, err_r, first_r;
  logic                    adv_a, accept;

  logic signed [EFF_W:0]        e;
  logic signed [EFF_W+30:0]     m_g00x0, m_g00x1;
  logic signed [EFF_W+23:0]     m_g10x0;
  logic signed [GAIN_W+EFF_W:0] m_l0e, m_l1e;
  logic signed [EFF_W+25:0]     m_h0u;
  logic signed [EFF_W+17:0]     m_h1u;
  logic signed [ACC_W-1:0]      a0, a1, a0_rnd, a1_rnd, diff;
  logic signed [EFF_W-1:0]      n0, n1, err;

  assign adv_a        = valid_a_r && (!valid_b_r || out_ch.ready);
  assign in_ch.ready  = gains.valid && (!valid_a_r || adv_a);
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    e       = (EFF_W+1)'(y_a_r) - (EFF_W+1)'(x1_r);
    m_g00x0 = C_G00 * x0_r;
    m_g00x1 = C_G00 * x1_r;
    m_g10x0 = C_G10 * x0_r;
    m_l0e   = gains.l0 * e;
    m_l1e   = gains.l1 * e;
    m_h0u   = C_H0 * u_a_r;
    m_h1u   = C_H1 * u_a_r;
    a0 = ACC_W'($signed(m_g00x0[EFF_W+30:22])) + ACC_W'($signed(m_l0e[GAIN_W+EFF_W:8]))
       + ACC_W'($signed(m_h0u[EFF_W+25:22]));
    a1 = ACC_W'($signed(m_g10x0[EFF_W+23:22])) + ACC_W'($signed(m_g00x1[EFF_W+30:22]))
       + ACC_W'($signed(m_l1e[GAIN_W+EFF_W:8])) + ACC_W'($signed(m_h1u[EFF_W+17:22]));
    a0_rnd = a0 + RND;
    a1_rnd = a1 + RND;
    n0     = sat_e(ACC_W'($signed(a0_rnd[ACC_W-1:8])));
    n1     = sat_e(ACC_W'($signed(a1_rnd[ACC_W-1:8])));
    diff   = ACC_W'(y_a_r) - ACC_W'(n1);
    err    = sat_e(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      x0_r      <= '0;
      x1_r      <= '0;
    end else begin
      if (accept) valid_a_r <= 1'b1;
      else if (adv_a) valid_a_r <= 1'b0;
      if (adv_a) valid_b_r <= 1'b1;
      else if (out_ch.ready) valid_b_r <= 1'b0;
      if (adv_a) begin
        x0_r <= n0;
        x1_r <= n1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u_a_r <= sat_e(ACC_W'($signed(in_ch.drive_voltage)));
      y_a_r <= sat_e(ACC_W'($signed(in_ch.measured_output)));
    end
    if (adv_a) begin
      est_r   <= IO_W'(n1);
      err_r   <= IO_W'(err);
      first_r <= IO_W'(n0);
    end
  end

  assign out_ch.valid                 = valid_b_r;
  assign out_ch.estimated_output      = est_r;
  assign out_ch.estimation_error      = err_r;
  assign out_ch.estimated_first_state = first_r;

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_a |=> $stable(x0_r) && $stable(x1_r))
    else $error("state estimate changed without an update");

  a_rise_from_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_b_r) |-> $past(adv_a))
    else $error("result valid rose without an update");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv_a |=> valid_b_r)
    else $error("update did not load the result register");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    valid_b_r |-> (est_r == IO_W'(x1_r)) && (first_r == IO_W'(x0_r)))
    else $error("pending result differs from the state estimate");

endmodule

// ===== hw/rtl/second_order_state_observer_top.sv =====
// second_order_state_observer_top: discrete second-order observer with pole-set gains
// depends on sso_pkg, sso_in_if, sso_out_if, sso_gain, sso_core
// path: an input transfer loads the input register; its update loads the result register once free
// throughput: one item per cycle while the output is ready, set by the single state-update pass
// reset clears poles and state; input ready stays low after reset or any register
// write while the gain pipeline settles
module second_order_state_observer_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sso_pkg::CFG_W-1:0]     cfg_data,
  sso_in_if.sink                        in_ch,
  sso_out_if.source                     out_ch
);
  import sso_pkg::*;

  localparam int EFF_W = (DATA_WIDTH > IO_W) ? IO_W : DATA_WIDTH;

  gain_bus_t gains;

  sso_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  sso_core #(
    .EFF_W (EFF_W)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .gains  (gains),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
